>>> rtl/gps_pkg.sv
package gps_pkg;

  localparam int GPS_INDEX_BITS = 16;
  localparam int GPS_FRAC_BITS  = 16;

  localparam int SD_BITS      = 31;
  localparam int E_BITS       = 31;
  localparam int TAYLOR_TERMS = 12;
  localparam int AB_QBITS     = 34;
  localparam int P_QBITS      = 61;

  localparam logic [E_BITS-1:0] Q30_ONE          = 31'h4000_0000;
  localparam logic [30:0]       INV_SQRT_2PI_Q32 = 31'd1713444047;

  localparam logic [1:0] CFG_MEAN  = 2'd0;
  localparam logic [1:0] CFG_STD   = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_INVALID = 2'd2
  } gps_status_t;

  typedef struct packed {
    logic        invalid;
    logic        sat;
    logic [31:0] x;
  } gps_side_t;

  // floor(2^32 / k)
  function automatic logic [32:0] gps_recip(input int k);
    logic [32:0] res;
    case (k)
      1:       res = 33'h1_0000_0000;
      2:       res = 33'd2147483648;
      3:       res = 33'd1431655765;
      4:       res = 33'd1073741824;
      5:       res = 33'd858993459;
      6:       res = 33'd715827882;
      7:       res = 33'd613566756;
      8:       res = 33'd536870912;
      9:       res = 33'd477218588;
      10:      res = 33'd429496729;
      11:      res = 33'd390451572;
      12:      res = 33'd357913941;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/gps_div_cell.sv
module gps_div_cell #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [DW-1:0]       in_rem,
  input  logic [QW-1:0]       in_word,
  input  gps_pkg::gps_side_t  in_side,
  input  logic [DW-1:0]       divisor,
  output logic                out_valid,
  output logic [DW-1:0]       out_rem,
  output logic [QW-1:0]       out_word,
  output gps_pkg::gps_side_t  out_side
);
  import gps_pkg::*;

  logic [DW:0]   trial;
  logic          fit;
  logic [DW-1:0] rem_nxt;
  logic [QW-1:0] word_nxt;

  logic          valid_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] word_r;
  gps_side_t     side_r;

  always_comb begin
    trial    = {in_rem, in_word[QW-1]};
    fit      = trial >= {1'b0, divisor};
    rem_nxt  = fit ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    word_nxt = {in_word[QW-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_word  = word_r;
  assign out_side  = side_r;

endmodule

>>> rtl/gps_divider.sv
module gps_divider #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [DW+QW-1:0]    in_num,
  input  gps_pkg::gps_side_t  in_side,
  input  logic [DW-1:0]       divisor,
  output logic                out_valid,
  output logic [QW-1:0]       out_quot,
  output logic [DW-1:0]       out_rem,
  output gps_pkg::gps_side_t  out_side
);
  import gps_pkg::*;

  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] word [0:QW];
  gps_side_t     side [0:QW];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_num[DW+QW-1:QW];
  assign word[0] = in_num[QW-1:0];
  assign side[0] = in_side;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    gps_div_cell #(
      .DW(DW),
      .QW(QW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[g]),
      .in_rem   (rem[g]),
      .in_word  (word[g]),
      .in_side  (side[g]),
      .divisor  (divisor),
      .out_valid(vld[g+1]),
      .out_rem  (rem[g+1]),
      .out_word (word[g+1]),
      .out_side (side[g+1])
    );
  end

  assign out_valid = vld[QW];
  assign out_quot  = word[QW];
  assign out_rem   = rem[QW];
  assign out_side  = side[QW];

endmodule

>>> rtl/gps_taylor_cell.sv
module gps_taylor_cell #(
  parameter int K = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [30:0]         in_v,
  input  logic [30:0]         in_e,
  input  gps_pkg::gps_side_t  in_side,
  output logic                out_valid,
  output logic [30:0]         out_v,
  output logic [30:0]         out_e,
  output gps_pkg::gps_side_t  out_side
);
  import gps_pkg::*;

  localparam logic [61:0] HALF_K = 62'(K) << 29;
  localparam logic [32:0] RECIP  = gps_recip(K);

  // stage 1: v*e
  logic        s1_valid_r;
  logic [61:0] s1_prod_r;
  logic [30:0] s1_v_r;
  gps_side_t   s1_side_r;

  // stage 2: w = round term / 2^30, w * recip(K)
  logic [61:0] wsum;
  logic [31:0] w_nxt;
  logic        s2_valid_r;
  logic [31:0] s2_w_r;
  logic [64:0] s2_mq_r;
  logic [30:0] s2_v_r;
  gps_side_t   s2_side_r;

  // stage 3: quotient correction, e = 1 - t
  logic [32:0] t0;
  logic [36:0] tk;
  logic [36:0] rem;
  logic [33:0] t;
  logic [30:0] e_nxt;
  logic        s3_valid_r;
  logic [30:0] s3_e_r;
  logic [30:0] s3_v_r;
  gps_side_t   s3_side_r;

  always_comb begin
    wsum  = s1_prod_r + HALF_K;
    w_nxt = wsum[61:30];
    t0    = s2_mq_r[64:32];
    tk    = 37'(t0) * 37'(K);
    rem   = 37'(s2_w_r) - tk;
    t     = (rem >= 37'(K)) ? 34'(t0) + 34'd1 : 34'(t0);
    e_nxt = (t >= 34'(Q30_ONE)) ? '0 : 31'(34'(Q30_ONE) - t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= 62'(in_v) * 62'(in_e);
    s1_v_r    <= in_v;
    s1_side_r <= in_side;
    s2_w_r    <= w_nxt;
    s2_mq_r   <= 65'(w_nxt) * 65'(RECIP);
    s2_v_r    <= s1_v_r;
    s2_side_r <= s1_side_r;
    s3_e_r    <= e_nxt;
    s3_v_r    <= s2_v_r;
    s3_side_r <= s2_side_r;
  end

  assign out_valid = s3_valid_r;
  assign out_v     = s3_v_r;
  assign out_e     = s3_e_r;
  assign out_side  = s3_side_r;

endmodule

>>> rtl/gaussian_pdf_sample_generator_top.sv
// Gaussian density sample generator. Write mean_value, std_dev and sample_count
// through the cfg port while no request is in flight, then issue sample
// indices with start; busy never rises, so one index is taken every cycle.
// Each result is strobed by out_valid for one cycle, in request order; there
// is no output back-pressure, so the consumer must take every strobe. The
// requests pass through bit-per-cycle divider chains (two parallel 34-cell
// chains for the grid position and standardized position, 61 cells for the
// deviation division) and twelve three-stage Taylor cells of the exponential.
// status is ok, saturated (x or density clipped) or invalid (count below two,
// index at or beyond count, zero deviation; x and density then read zero).
module gaussian_pdf_sample_generator_top #(
  parameter int INDEX_BITS = gps_pkg::GPS_INDEX_BITS,
  parameter int FRAC_BITS  = gps_pkg::GPS_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] in_sample_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_addr,
  input  logic [31:0]           cfg_wdata,
  output logic                  out_valid,
  output logic [31:0]           out_x_value,
  output logic [31:0]           out_density,
  output logic [1:0]            out_status
);
  import gps_pkg::*;

  localparam int COUNT_BITS = INDEX_BITS + 1;
  localparam int DA_W       = COUNT_BITS + 1;
  localparam int NUM_W      = DA_W + AB_QBITS;
  localparam int SDI_W      = SD_BITS + INDEX_BITS;
  localparam int DEN_SHIFT  = 62 - 2 * FRAC_BITS;
  localparam int LATENCY    = 2 + AB_QBITS + 3 + 3 * TAYLOR_TERMS + 3 + 1 + P_QBITS + 1;

  localparam logic [33:0]        THREE_Q30 = 34'h0_C000_0000;
  localparam logic signed [37:0] X_MAX     = 38'sd2147483647;
  localparam logic signed [37:0] X_MIN     = -38'sd2147483648;

  // configuration
  logic [31:0]           mean_r;
  logic [SD_BITS-1:0]    sd_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] n1;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      sd_r    <= SD_BITS'(65536);
      count_r <= COUNT_BITS'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_MEAN:  mean_r  <= cfg_wdata;
        CFG_STD:   sd_r    <= cfg_wdata[SD_BITS-1:0];
        CFG_COUNT: count_r <= cfg_wdata[COUNT_BITS-1:0];
        default:   ;
      endcase
    end
  end

  assign n1 = count_r - COUNT_BITS'(1);

  // stage 0: request check, sd*i
  logic                  inv_nxt;
  logic                  s0_valid_r;
  logic [INDEX_BITS-1:0] s0_idx_r;
  logic                  s0_inv_r;
  logic [SDI_W-1:0]      s0_sdi_r;

  assign inv_nxt = (count_r < COUNT_BITS'(2)) || ({1'b0, in_sample_index} >= count_r) ||
                   (sd_r == '0);

  // stage 1: dividends
  logic [NUM_W-1:0] num_a_nxt;
  logic [NUM_W-1:0] num_b_nxt;
  logic             s1_valid_r;
  logic [NUM_W-1:0] s1_num_a_r;
  logic [NUM_W-1:0] s1_num_b_r;
  gps_side_t        s1_side_r;
  gps_side_t        s1_side_nxt;
  logic [DA_W-1:0]  div_ab;

  always_comb begin
    num_a_nxt = (NUM_W'(s0_sdi_r) << 3) + (NUM_W'(s0_sdi_r) << 2) + NUM_W'(n1);
    num_b_nxt = (((NUM_W'(s0_idx_r) << 3) + (NUM_W'(s0_idx_r) << 2)) << 30) + NUM_W'(n1);
    s1_side_nxt         = '0;
    s1_side_nxt.invalid = s0_inv_r;
  end

  assign div_ab = {n1, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx_r   <= in_sample_index;
    s0_inv_r   <= inv_nxt;
    s0_sdi_r   <= SDI_W'(sd_r) * SDI_W'(in_sample_index);
    s1_num_a_r <= num_a_nxt;
    s1_num_b_r <= num_b_nxt;
    s1_side_r  <= s1_side_nxt;
  end

  // grid offset q and standardized position r
  logic                da_valid;
  logic [AB_QBITS-1:0] da_quot;
  logic [AB_QBITS-1:0] db_quot;
  gps_side_t           da_side;

  gps_divider #(
    .DW(DA_W),
    .QW(AB_QBITS)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid_r),
    .in_num   (s1_num_a_r),
    .in_side  (s1_side_r),
    .divisor  (div_ab),
    .out_valid(da_valid),
    .out_quot (da_quot),
    .out_rem  (),
    .out_side (da_side)
  );

  gps_divider #(
    .DW(DA_W),
    .QW(AB_QBITS)
  ) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid_r),
    .in_num   (s1_num_b_r),
    .in_side  (s1_side_r),
    .divisor  (div_ab),
    .out_valid(),
    .out_quot (db_quot),
    .out_rem  (),
    .out_side ()
  );

  // x and |a|
  logic [37:0]        sd3;
  logic signed [37:0] xsum;
  logic [33:0]        m_full;
  gps_side_t          x_side_nxt;
  logic               x_valid_r;
  logic [31:0]        x_m_r;
  gps_side_t          x_side_r;

  always_comb begin
    sd3    = 38'(sd_r) + (38'(sd_r) << 1);
    xsum   = $signed({{6{mean_r[31]}}, mean_r}) - $signed(sd3) + $signed({4'b0, da_quot});
    m_full = (db_quot >= THREE_Q30) ? db_quot - THREE_Q30 : THREE_Q30 - db_quot;
    x_side_nxt         = da_side;
    x_side_nxt.sat     = 1'b0;
    x_side_nxt.x       = xsum[31:0];
    if (xsum > X_MAX) begin
      x_side_nxt.sat = 1'b1;
      x_side_nxt.x   = 32'h7FFF_FFFF;
    end else if (xsum < X_MIN) begin
      x_side_nxt.sat = 1'b1;
      x_side_nxt.x   = 32'h8000_0000;
    end
  end

  // a*a, then v = u/8
  logic        mm_valid_r;
  logic [63:0] mm_r;
  gps_side_t   mm_side_r;
  logic [64:0] usum;
  logic [34:0] vsum;
  logic        v_valid_r;
  logic [30:0] v_r;
  gps_side_t   v_side_r;

  always_comb begin
    usum = 65'(mm_r) + (65'(1) << 30);
    vsum = 35'(usum[64:31]) + 35'd4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r  <= 1'b0;
      mm_valid_r <= 1'b0;
      v_valid_r  <= 1'b0;
    end else begin
      x_valid_r  <= da_valid;
      mm_valid_r <= x_valid_r;
      v_valid_r  <= mm_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    x_m_r     <= m_full[31:0];
    x_side_r  <= x_side_nxt;
    mm_r      <= 64'(x_m_r) * 64'(x_m_r);
    mm_side_r <= x_side_r;
    v_r       <= vsum[33:3];
    v_side_r  <= mm_side_r;
  end

  // Horner chain of exp(-v)
  logic        t_valid [0:TAYLOR_TERMS];
  logic [30:0] t_v     [0:TAYLOR_TERMS-1];
  logic [30:0] t_e     [0:TAYLOR_TERMS];
  gps_side_t   t_side  [0:TAYLOR_TERMS];

  assign t_valid[0] = v_valid_r;
  assign t_v[0]     = v_r;
  assign t_e[0]     = Q30_ONE;
  assign t_side[0]  = v_side_r;

  for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_taylor
    if (g < TAYLOR_TERMS - 1) begin : g_mid
      gps_taylor_cell #(
        .K(TAYLOR_TERMS - g)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (t_valid[g]),
        .in_v     (t_v[g]),
        .in_e     (t_e[g]),
        .in_side  (t_side[g]),
        .out_valid(t_valid[g+1]),
        .out_v    (t_v[g+1]),
        .out_e    (t_e[g+1]),
        .out_side (t_side[g+1])
      );
    end else begin : g_last
      gps_taylor_cell #(
        .K(TAYLOR_TERMS - g)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (t_valid[g]),
        .in_v     (t_v[g]),
        .in_e     (t_e[g]),
        .in_side  (t_side[g]),
        .out_valid(t_valid[g+1]),
        .out_v    (),
        .out_e    (t_e[g+1]),
        .out_side (t_side[g+1])
      );
    end
  end

  // three squarings undo the /8
  logic        sq_valid_r [0:2];
  logic [30:0] sq_e_r     [0:2];
  gps_side_t   sq_side_r  [0:2];
  logic        sq_src_v   [0:2];
  logic [30:0] sq_src_e   [0:2];
  gps_side_t   sq_src_s   [0:2];
  logic [61:0] sq_prod    [0:2];

  for (genvar s = 0; s < 3; s++) begin : g_sq
    if (s == 0) begin : g_first
      assign sq_src_v[s] = t_valid[TAYLOR_TERMS];
      assign sq_src_e[s] = t_e[TAYLOR_TERMS];
      assign sq_src_s[s] = t_side[TAYLOR_TERMS];
    end else begin : g_next
      assign sq_src_v[s] = sq_valid_r[s-1];
      assign sq_src_e[s] = sq_e_r[s-1];
      assign sq_src_s[s] = sq_side_r[s-1];
    end

    assign sq_prod[s] = 62'(sq_src_e[s]) * 62'(sq_src_e[s]) + (62'(1) << 29);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[s] <= 1'b0;
      end else begin
        sq_valid_r[s] <= sq_src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      sq_e_r[s]    <= sq_prod[s][60:30];
      sq_side_r[s] <= sq_src_s[s];
    end
  end

  // scale by 1/sqrt(2pi), divide by sd
  logic         p_valid_r;
  logic [61:0]  p_r;
  gps_side_t    p_side_r;
  logic         dp_valid;
  logic [P_QBITS-1:0] dp_quot;
  gps_side_t    dp_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= sq_valid_r[2];
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= 62'(sq_e_r[2]) * 62'(INV_SQRT_2PI_Q32);
    p_side_r <= sq_side_r[2];
  end

  gps_divider #(
    .DW(SD_BITS),
    .QW(P_QBITS)
  ) u_div_sd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (p_valid_r),
    .in_num   ((SD_BITS + P_QBITS)'(p_r)),
    .in_side  (p_side_r),
    .divisor  (sd_r),
    .out_valid(dp_valid),
    .out_quot (dp_quot),
    .out_rem  (),
    .out_side (dp_side)
  );

  // round, saturate, register result
  logic [61:0] dsum;
  logic [61:0] dfull;
  logic        sat_d;
  logic [31:0] dens_nxt;
  logic [31:0] x_nxt;
  gps_status_t status_nxt;

  logic        out_valid_r;
  logic [31:0] out_x_r;
  logic [31:0] out_dens_r;
  gps_status_t out_status_r;

  always_comb begin
    dsum  = 62'(dp_quot) + (62'(1) << (DEN_SHIFT - 1));
    dfull = dsum >> DEN_SHIFT;
    sat_d = dfull > 62'(32'hFFFF_FFFF);
    if (dp_side.invalid) begin
      x_nxt      = '0;
      dens_nxt   = '0;
      status_nxt = ST_INVALID;
    end else begin
      x_nxt      = dp_side.x;
      dens_nxt   = sat_d ? 32'hFFFF_FFFF : dfull[31:0];
      status_nxt = (dp_side.sat || sat_d) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r      <= x_nxt;
    out_dens_r   <= dens_nxt;
    out_status_r <= status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_x_value = out_x_r;
  assign out_density = out_dens_r;
  assign out_status  = out_status_r;

`ifndef SYNTH
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INVALID) |-> (out_x_value == '0 && out_density == '0))
    else $error("invalid request with nonzero payload");
`endif

endmodule
